// ----- hdl/sgv_pkg.sv -----
// Shared types, constants and tables of the sphere grid vertex generator.
// Used by every module of the block; depends on nothing.
package sgv_pkg;

    localparam int STEP_BITS       = 8;
    localparam int COORD_FRAC_BITS = 15;
    localparam int INDEX_BITS      = 16;
    localparam int COORD_BITS      = 16;

    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LAT_CELLS = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LON_CELLS = 2'd1;
    localparam logic [STEP_BITS-1:0] LAT_CELLS_RESET = STEP_BITS'(16);
    localparam logic [STEP_BITS-1:0] LON_CELLS_RESET = STEP_BITS'(16);

    // Phase arithmetic: one full turn is 2^PHASE_BITS.
    localparam int PHASE_BITS     = 32;
    localparam int QUOT_BITS      = PHASE_BITS + 1;
    localparam int REM_BITS       = STEP_BITS + 1;
    localparam int DIV_STAGES     = 8;
    localparam int DIV_BITS_STAGE = PHASE_BITS / DIV_STAGES;
    localparam logic [PHASE_BITS-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [PHASE_BITS-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam int CORDIC_STAGES = 16;
    localparam int CW            = 34;
    localparam int SAMPLE_BITS   = 32;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [PHASE_BITS-1:0] ATAN_TURNS [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    localparam int SHIFT_PROD   = 61 - COORD_FRAC_BITS;
    localparam int SHIFT_SAMPLE = 31 - COORD_FRAC_BITS;

    localparam int LATENCY = DIV_STAGES + CORDIC_STAGES + 2;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int PTR_BITS  = 2;
    localparam int CNT_BITS  = 3;

    typedef logic [STEP_BITS-1:0] step_t;

    typedef struct packed {
        step_t lat_cells;
        step_t lon_cells;
    } cfg_t;

    typedef struct packed {
        step_t                  lat;
        step_t                  lon;
        logic                   err;
        logic [INDEX_BITS-1:0]  index;
    } item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]         index;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  z;
        logic                          err;
    } result_t;

endpackage

// ----- hdl/sphere_grid_vertex_generator.sv -----
// UV sphere vertex generator: one grid point in, one vertex index and position
// out. Uses sgv_pkg, sgv_front and sgv_back.
//
// Each request (lat_step, lon_step) yields one result, in order, with the
// vertex index and the x, y, z position on a sphere of radius 0.5 in signed
// fixed point. The block takes a new request every cycle while the input
// queue is not full; each result passes through the input queue, the
// 8-stage angle divider, the 16-stage CORDIC pipeline, the product and rounding
// stages and the write into the result queue.
// Four-entry queues sit at the input and at the result side, so the pipeline
// holds still only while the result queue is full. Steps beyond the cell
// counts give range_error with all other fields zero. Write lat_cells and
// lon_cells only while no request is in flight.
module sphere_grid_vertex_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  sgv_pkg::step_t                        lat_step,
    input  sgv_pkg::step_t                        lon_step,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [sgv_pkg::INDEX_BITS-1:0]        vertex_index,
    output logic signed [sgv_pkg::COORD_BITS-1:0] pos_x,
    output logic signed [sgv_pkg::COORD_BITS-1:0] pos_y,
    output logic signed [sgv_pkg::COORD_BITS-1:0] pos_z,
    output logic                                  range_error,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sgv_pkg::CFG_ADDR_BITS-1:0]     cfg_index,
    input  sgv_pkg::step_t                        cfg_data
);
    import sgv_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    item_t   item;
    result_t result;
    logic    take, avail;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LAT_CELLS: cfg_next.lat_cells = cfg_data;
                CFG_LON_CELLS: cfg_next.lon_cells = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lat_cells <= LAT_CELLS_RESET;
            cfg_reg.lon_cells <= LON_CELLS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sgv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .lat_step (lat_step),
        .lon_step (lon_step),
        .take     (take),
        .avail    (avail),
        .item     (item)
    );

    sgv_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .avail  (avail),
        .item   (item),
        .take   (take),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    assign vertex_index = result.index;
    assign pos_x        = result.x;
    assign pos_y        = result.y;
    assign pos_z        = result.z;
    assign range_error  = result.err;

endmodule

// ----- hdl/sgv_front.sv -----
// Front end: accepts grid points, checks them against the cell counts and
// works out the vertex index, then queues them for the back end. Uses sgv_pkg.
module sgv_front (
    input  logic           clk,
    input  logic           rst_n,
    input  sgv_pkg::cfg_t  cfg,
    input  logic           push,
    output logic           full,
    input  sgv_pkg::step_t lat_step,
    input  sgv_pkg::step_t lon_step,
    input  logic           take,
    output logic           avail,
    output sgv_pkg::item_t item
);
    import sgv_pkg::*;

    localparam int IDX_W = 2 * STEP_BITS + 2;

    item_t               mem_reg [MID_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;
    item_t               new_item;
    logic [IDX_W-1:0]    index_full;

    assign full    = (count_reg == CNT_BITS'(MID_DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = take && avail;
    assign item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        index_full = IDX_W'(lat_step) * (IDX_W'(cfg.lon_cells) + IDX_W'(1))
                     + IDX_W'(lon_step);
        new_item.lat   = lat_step;
        new_item.lon   = lon_step;
        // A zero cell count turns every point into an error.
        new_item.err   = (cfg.lat_cells == '0) || (cfg.lon_cells == '0) ||
                         (lat_step > cfg.lat_cells) || (lon_step > cfg.lon_cells);
        new_item.index = index_full[INDEX_BITS-1:0];
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- hdl/sgv_divider.sv -----
// Pipelined restoring divider giving floor(a * 2^32 / n), 33 bits, four
// fractional quotient bits per stage. Uses sgv_pkg.
module sgv_divider (
    input  logic                          clk,
    input  logic                          adv,
    input  sgv_pkg::step_t                a,
    input  sgv_pkg::step_t                n,
    output logic [sgv_pkg::QUOT_BITS-1:0] quot
);
    import sgv_pkg::*;

    logic [REM_BITS-1:0]  rem_reg [DIV_STAGES];
    logic [QUOT_BITS-1:0] quo_reg [DIV_STAGES];
    logic [REM_BITS-1:0]  den;

    assign den  = {1'b0, n};
    assign quot = quo_reg[DIV_STAGES-1];

    genvar s;
    for (s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [REM_BITS-1:0]  r_in, r_work, r_out;
        logic [QUOT_BITS-1:0] q_in, q_out;

        if (s == 0)
        begin : g_first
            // The whole part of the quotient is one bit, set whenever a >= n (for valid points, only at a == n).
            always_comb
            begin
                if ({1'b0, a} >= den)
                begin
                    r_in = {1'b0, a} - den;
                    q_in = QUOT_BITS'(1);
                end
                else
                begin
                    r_in = {1'b0, a};
                    q_in = '0;
                end
            end
        end
        else
        begin : g_rest
            assign r_in = rem_reg[s-1];
            assign q_in = quo_reg[s-1];
        end

        always_comb
        begin
            r_out = r_in;
            q_out = q_in;
            for (int b = 0; b < DIV_BITS_STAGE; b++)
            begin
                r_work = {r_out[REM_BITS-2:0], 1'b0};
                if (r_work >= den)
                begin
                    r_out = r_work - den;
                    q_out = {q_out[QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_out = r_work;
                    q_out = {q_out[QUOT_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= r_out;
                quo_reg[s] <= q_out;
            end
        end
    end

endmodule

// ----- hdl/sgv_cordic.sv -----
// Pipelined rotation-mode CORDIC: sine and cosine of a phase in turns,
// one micro-rotation per stage. Uses sgv_pkg.
module sgv_cordic (
    input  logic                                   clk,
    input  logic                                   adv,
    input  logic [sgv_pkg::PHASE_BITS-1:0]         phase,
    output logic signed [sgv_pkg::SAMPLE_BITS-1:0] sn,
    output logic signed [sgv_pkg::SAMPLE_BITS-1:0] cs
);
    import sgv_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES];
    logic                 neg_reg [CORDIC_STAGES];

    logic                  neg0;
    logic [PHASE_BITS-1:0] p0, pq;
    logic signed [CW-1:0]  y_fin, x_fin;

    // Fold the phase into the half turn around zero; for a folded phase the result is negated.
    always_comb
    begin
        pq   = phase + QUARTER_TURN;
        neg0 = pq[PHASE_BITS-1];
        p0   = neg0 ? phase - HALF_TURN : phase;
    end

    always_comb
    begin
        y_fin = neg_reg[CORDIC_STAGES-1] ? -y_reg[CORDIC_STAGES-1] : y_reg[CORDIC_STAGES-1];
        x_fin = neg_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1] : x_reg[CORDIC_STAGES-1];
    end

    assign sn = y_fin[SAMPLE_BITS-1:0];
    assign cs = x_fin[SAMPLE_BITS-1:0];

    genvar i;
    for (i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [CW-1:0] x_in, y_in, z_in, x_out, y_out, z_out, dx, dy, ang;
        logic                 neg_in;

        if (i == 0)
        begin : g_first
            assign x_in   = GAIN_Q30;
            assign y_in   = '0;
            assign z_in   = signed'({{(CW-PHASE_BITS){p0[PHASE_BITS-1]}}, p0});
            assign neg_in = neg0;
        end
        else
        begin : g_rest
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        assign ang = signed'({{(CW-PHASE_BITS){1'b0}}, ATAN_TURNS[i]});
        assign dx  = y_in >>> i;
        assign dy  = x_in >>> i;

        always_comb
        begin
            if (!z_in[CW-1])
            begin
                x_out = x_in - dx;
                y_out = y_in + dy;
                z_out = z_in - ang;
            end
            else
            begin
                x_out = x_in + dx;
                y_out = y_in - dy;
                z_out = z_in + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i]   <= x_out;
                y_reg[i]   <= y_out;
                z_reg[i]   <= z_out;
                neg_reg[i] <= neg_in;
            end
        end
    end

endmodule

// ----- hdl/sgv_back.sv -----
// Back end: angle division, sine and cosine, products, rounding and the
// result queue, all advancing in lock step. Uses sgv_pkg, sgv_divider, sgv_cordic.
module sgv_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sgv_pkg::cfg_t    cfg,
    input  logic             avail,
    input  sgv_pkg::item_t   item,
    output logic             take,
    input  logic             pop,
    output logic             empty,
    output sgv_pkg::result_t result
);
    import sgv_pkg::*;

    function automatic logic [COORD_BITS-1:0] to_coord(input logic signed [PROD_BITS:0] v,
                                                       input int s);
        logic signed [PROD_BITS:0] r;
        logic signed [PROD_BITS:0] lim;
        lim = (PROD_BITS+1)'(1) <<< (COORD_FRAC_BITS - 1);
        r   = (v + ((PROD_BITS+1)'(1) <<< (s - 1))) >>> s;
        if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r[COORD_BITS-1:0];
    endfunction

    logic adv;

    logic                  valid_reg [LATENCY];
    logic                  err_reg   [LATENCY];
    logic [INDEX_BITS-1:0] idx_reg   [LATENCY];

    logic [QUOT_BITS-1:0]  lon_q, lat_q;
    logic [PHASE_BITS-1:0] lon_ph, lat_ph;
    logic signed [SAMPLE_BITS-1:0] sl, cl, sb, cb;

    logic signed [PROD_BITS-1:0]   px_reg, pz_reg;
    logic signed [SAMPLE_BITS-1:0] py_reg;
    logic signed [COORD_BITS-1:0]  rx_reg, ry_reg, rz_reg;

    result_t             mem_reg [OUT_DEPTH];
    result_t             done;
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign adv  = (count_reg != CNT_BITS'(OUT_DEPTH));
    assign take = adv && avail;

    sgv_divider u_lon_div (
        .clk  (clk),
        .adv  (adv),
        .a    (item.lon),
        .n    (cfg.lon_cells),
        .quot (lon_q)
    );

    sgv_divider u_lat_div (
        .clk  (clk),
        .adv  (adv),
        .a    (item.lat),
        .n    (cfg.lat_cells),
        .quot (lat_q)
    );

    // Longitude starts half a turn round; latitude starts at the south pole.
    assign lon_ph = lon_q[PHASE_BITS-1:0] + HALF_TURN;
    assign lat_ph = lat_q[QUOT_BITS-1:1] - QUARTER_TURN;

    sgv_cordic u_lon_cordic (
        .clk   (clk),
        .adv   (adv),
        .phase (lon_ph),
        .sn    (sl),
        .cs    (cl)
    );

    sgv_cordic u_lat_cordic (
        .clk   (clk),
        .adv   (adv),
        .phase (lat_ph),
        .sn    (sb),
        .cs    (cb)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= sl * cb;
            pz_reg <= cl * cb;
            py_reg <= sb;
            rx_reg <= signed'(to_coord((PROD_BITS+1)'(px_reg), SHIFT_PROD));
            rz_reg <= signed'(to_coord((PROD_BITS+1)'(pz_reg), SHIFT_PROD));
            ry_reg <= signed'(to_coord((PROD_BITS+1)'(py_reg), SHIFT_SAMPLE));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LATENCY; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= avail;
            for (int k = 1; k < LATENCY; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg[0] <= item.err;
            idx_reg[0] <= item.index;
            for (int k = 1; k < LATENCY; k++)
            begin
                err_reg[k] <= err_reg[k-1];
                idx_reg[k] <= idx_reg[k-1];
            end
        end
    end

    // An out-of-range request leaves with its error flag set and all other result fields cleared.
    always_comb
    begin
        if (err_reg[LATENCY-1])
        begin
            done.index = '0;
            done.x     = '0;
            done.y     = '0;
            done.z     = '0;
            done.err   = 1'b1;
        end
        else
        begin
            done.index = idx_reg[LATENCY-1];
            done.x     = rx_reg;
            done.y     = ry_reg;
            done.z     = rz_reg;
            done.err   = 1'b0;
        end
    end

    assign do_push = adv && valid_reg[LATENCY-1];
    assign empty   = (count_reg == '0);
    assign do_pop  = pop && !empty;
    assign result  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= done;
        end
    end

endmodule

// ----- tb/sphere_grid_vertex_generator_tb.sv -----
// Self-checking testbench of the sphere grid vertex generator: predicts each
// vertex index and position and compares it with the block. Uses sgv_pkg.
module sphere_grid_vertex_generator_tb;

    import sgv_pkg::*;

    typedef struct {
        logic [15:0]        index;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               err;
    } vertex_t;

    localparam logic [31:0] TURN_ATAN [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };
    localparam longint CYCLE_LIMIT = 400000;
    // Register indexes that map to no register.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_NO_REG_2 = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_NO_REG_3 = 2'd3;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    step_t lat_step;
    step_t lon_step;
    logic empty;
    logic pop;
    logic [INDEX_BITS-1:0] vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic range_error;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_index;
    step_t cfg_data;

    step_t lat_cells_m;
    step_t lon_cells_m;
    vertex_t pending_vertices[$];
    int mismatches;
    int push_idle_pct;
    int pop_idle_pct;
    longint cycle_count;

    sphere_grid_vertex_generator uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .lat_step(lat_step), .lon_step(lon_step), .empty(empty), .pop(pop),
        .vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .range_error(range_error), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sphere_grid_vertex_generator_tb failed");
            $finish;
        end
    end

    // The arithmetic shift of a signed value already floors.
    function automatic void cordic_sin_cos(input logic [31:0] phase,
                                           output longint sn, output longint cs);
        logic        flip;
        logic [31:0] folded;
        longint      xv;
        longint      yv;
        longint      zv;
        longint      dx;
        longint      dy;
        flip = ((phase + 32'h4000_0000) & 32'h8000_0000) != 0;
        folded = flip ? phase - 32'h8000_0000 : phase;
        zv = longint'(signed'(folded));
        xv = 652032874;
        yv = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (zv >= 0)
            begin
                xv = xv - dx; yv = yv + dy; zv = zv - longint'(TURN_ATAN[i]);
            end
            else
            begin
                xv = xv + dx; yv = yv - dy; zv = zv + longint'(TURN_ATAN[i]);
            end
        end
        sn = flip ? -yv : yv;
        cs = flip ? -xv : xv;
    endfunction

    function automatic logic [15:0] round_coord(input longint v, input int s);
        longint r;
        r = (v + (longint'(1) << (s - 1))) >>> s;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic vertex_t predict_vertex(input step_t lat, input step_t lon);
        vertex_t v;
        logic [63:0] lon_q;
        logic [63:0] lat_q;
        logic [31:0] lon_ph;
        logic [31:0] lat_ph;
        longint sl, cl, sb, cb;
        v = '{default: '0};
        if (lat_cells_m == 0 || lon_cells_m == 0 || lat > lat_cells_m || lon > lon_cells_m)
        begin
            v.err = 1'b1;
            return v;
        end
        lon_q = (64'(lon) << 32) / 64'(lon_cells_m);
        lat_q = (64'(lat) << 31) / 64'(lat_cells_m);
        lon_ph = lon_q[31:0] + 32'h8000_0000;
        lat_ph = lat_q[31:0] - 32'h4000_0000;
        cordic_sin_cos(lon_ph, sl, cl);
        cordic_sin_cos(lat_ph, sb, cb);
        v.index = 16'(32'(lat) * (32'(lon_cells_m) + 1) + 32'(lon));
        v.x = round_coord(sl * cb, 46);
        v.y = round_coord(sb, 16);
        v.z = round_coord(cl * cb, 46);
        return v;
    endfunction

    // Result checker: compares every popped vertex with the oldest prediction.
    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result index %0d", vertex_index);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (want.index !== vertex_index || want.x !== pos_x || want.y !== pos_y
                    || want.z !== pos_z || want.err !== range_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %0d %0d %0d %0d %b got %0d %0d %0d %0d %b",
                                 want.index, want.x, want.y, want.z, want.err,
                                 vertex_index, pos_x, pos_y, pos_z, range_error);
                end
            end
        end
    end

    // Random stalls of the result side.
    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    // Leaves push high on return, so that the next request can follow at once.
    task automatic send_point(input step_t lat, input step_t lon);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        lat_step <= lat;
        lon_step <= lon;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_vertices.push_back(predict_vertex(lat, lon));
        @(negedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_vertices.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_BITS-1:0] idx, input step_t val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_LAT_CELLS)
            lat_cells_m = val;
        else if (idx == CFG_LON_CELLS)
            lon_cells_m = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_points();
        send_point(0, 0);
        send_point(16, 16);
        send_point(8, 4);
        send_point(17, 0);
        send_point(0, 17);
        send_point(255, 255);
        send_point(8'hAA, 8'h55);
        send_point(8'h55, 8'hAA);
        write_register(CFG_LAT_CELLS, 255);
        write_register(CFG_LON_CELLS, 255);
        send_point(255, 255);
        send_point(0, 255);
        send_point(128, 64);
        send_point(255, 0);
        write_register(CFG_LAT_CELLS, 1);
        write_register(CFG_LON_CELLS, 1);
        send_point(0, 0);
        send_point(1, 1);
        send_point(2, 1);
        // A zero cell count turns every point into an error.
        write_register(CFG_LAT_CELLS, 0);
        send_point(0, 0);
        write_register(CFG_LAT_CELLS, 16);
        write_register(CFG_LON_CELLS, 0);
        send_point(0, 0);
        // An index beyond the two registers must leave both unchanged.
        write_register(CFG_NO_REG_2, 8'd7);
        write_register(CFG_NO_REG_3, 8'd9);
        write_register(CFG_LON_CELLS, 16);
        send_point(3, 5);
    endtask

    task automatic test_random_points(input int count);
        step_t lat;
        step_t lon;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) < 8)
            begin
                lat = step_t'($urandom_range(lat_cells_m));
                lon = step_t'($urandom_range(lon_cells_m));
            end
            else
            begin
                lat = step_t'($urandom);
                lon = step_t'($urandom);
            end
            send_point(lat, lon);
        end
    endtask

    task automatic test_random_settings();
        int phase_no;
        for (phase_no = 0; phase_no < 9; phase_no++)
        begin
            case (phase_no % 3)
                0: begin push_idle_pct = 29; pop_idle_pct = 57; end
                1: begin push_idle_pct = 57; pop_idle_pct = 29; end
                default: begin push_idle_pct = 0; pop_idle_pct = 0; end
            endcase
            write_register(CFG_LAT_CELLS, step_t'($urandom_range(1, 255)));
            write_register(CFG_LON_CELLS,
                           (phase_no == 4) ? 8'd255 : step_t'($urandom_range(1, 255)));
            test_random_points(205);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        lat_step = '0;
        lon_step = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        lat_cells_m = LAT_CELLS_RESET;
        lon_cells_m = LON_CELLS_RESET;
        mismatches = 0;
        cycle_count = 0;
        push_idle_pct = 29;
        pop_idle_pct = 57;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_points();
        test_random_settings();
        drain_results();
        if (mismatches == 0)
            $display("sphere_grid_vertex_generator_tb passed");
        else
            $display("sphere_grid_vertex_generator_tb failed");
        $finish;
    end

endmodule

// ----- sphere_grid_vertex_generator.f -----
hdl/sgv_pkg.sv
hdl/sgv_front.sv
hdl/sgv_divider.sv
hdl/sgv_cordic.sv
hdl/sgv_back.sv
hdl/sphere_grid_vertex_generator.sv
tb/sphere_grid_vertex_generator_tb.sv
